// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg : shared types and constants for the bounded deque
// Request/response structs, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdq_pkg;

  // Storage geometry, tied to the fixed position and count field widths
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FUNC_W = 3;
  localparam int STAT_W = 2;

  // Request operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REMOVE_AT  = 3'd4;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // Cell commands broadcast along the chain
  localparam logic [1:0] CELL_HOLD = 2'd0;  // keep own word
  localparam logic [1:0] CELL_SHR  = 2'd1;  // take left neighbour, cell 0 loads
  localparam logic [1:0] CELL_LOAD = 2'd2;  // cell at idx loads new word
  localparam logic [1:0] CELL_SHL  = 2'd3;  // cells at idx and above take right

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value_in;
    logic [IDX_W-1:0]         position;
  } bdq_req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] removed_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
  } bdq_rsp_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
  } bdq_cmd_t;

endpackage

// ===== rtl/bounded_deque_with_indexed_delete_top.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_delete_top : bounded deque with indexed removal
// Response strobes in the cycle after the request is taken.
// Throughput: one request per cycle; busy stays low, all cells shift at once.
// The receiver cannot stall; every request yields exactly one response.
// Reset (synchronous, rst_n low) empties the deque and drops the strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_deque_with_indexed_delete_top
  import bdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bdq_req_t in_req,
  output logic     out_valid,
  output bdq_rsp_t out_rsp
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic                accept;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                out_valid_r;
  bdq_rsp_t            out_rsp_r;
  bdq_rsp_t            rsp_nxt;
  bdq_cmd_t            cmd;
  logic [IDX_W-1:0]    rd_idx;
  logic                do_remove;
  logic                cnt_zero;
  logic                cnt_full;
  logic [DATA_W-1:0]   cell_q [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start & ~busy;
  assign cnt_zero = (cnt_r == '0);
  assign cnt_full = (cnt_r == CNT_FULL);

  // Decode request into a chain command, status and next count
  always_comb begin
    cmd.op          = CELL_HOLD;
    cmd.idx         = '0;
    cmd.value       = in_req.value_in;
    cnt_nxt         = cnt_r;
    rd_idx          = '0;
    do_remove       = 1'b0;
    rsp_nxt.status  = ST_OK;
    case (in_req.func)
      FN_PUSH_FRONT: begin
        if (cnt_full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          cmd.op  = CELL_SHR;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (cnt_full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          cmd.op  = CELL_LOAD;
          cmd.idx = cnt_r[IDX_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (cnt_zero) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          cmd.op    = CELL_SHL;
          cmd.idx   = '0;
          rd_idx    = '0;
          do_remove = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      FN_POP_BACK: begin
        if (cnt_zero) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          // last word just drops off, nothing moves
          rd_idx    = IDX_W'(cnt_r - 1'b1);
          do_remove = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      FN_REMOVE_AT: begin
        if (cnt_zero) begin
          rsp_nxt.status = ST_EMPTY;
        end else if (CNT_W'(in_req.position) >= cnt_r) begin
          rsp_nxt.status = ST_RANGE;
        end else begin
          cmd.op    = CELL_SHL;
          cmd.idx   = in_req.position;
          rd_idx    = in_req.position;
          do_remove = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      default: begin
        cmd.op = CELL_HOLD;
      end
    endcase
    if (!accept) begin
      cmd.op  = CELL_HOLD;
      cnt_nxt = cnt_r;
    end
    rsp_nxt.removed_value = do_remove ? cell_q[rd_idx] : '0;
    rsp_nxt.count         = cnt_nxt;
    rsp_nxt.is_empty      = (cnt_nxt == '0);
  end

  // Row of cells; the last cell's right neighbour is itself
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_q[0];
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    bdq_cell #(
      .CELL_IDX (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_q  (left_w),
      .right_q (right_w),
      .data_q  (cell_q[i])
    );
  end

  // Count and response strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above capacity");

  a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("request without response");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid_r)
    else $error("response without request");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rsp_r.status == ST_FULL) |-> out_rsp_r.count == CNT_FULL)
    else $error("full status with room left");

  a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.count == cnt_r && out_rsp_r.is_empty == (cnt_r == '0)))
    else $error("response count differs from held count");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cnt_full &&
     (in_req.func == FN_PUSH_FRONT || in_req.func == FN_PUSH_BACK))
    |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push did not grow the deque");

endmodule

// ===== rtl/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// bdq_cell : one storage cell of the deque chain
// Holds one word; each cycle keeps it, loads a new word, or takes a neighbour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdq_cell
  import bdq_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  bdq_cmd_t          cmd,
  input  logic [DATA_W-1:0] left_q,
  input  logic [DATA_W-1:0] right_q,
  output logic [DATA_W-1:0] data_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Next word from the broadcast command and this cell's place in the row
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      CELL_SHR: begin
        data_nxt = (CELL_IDX == 0) ? cmd.value : left_q;
      end
      CELL_LOAD: begin
        if (cmd.idx == MY_IDX) data_nxt = cmd.value;
      end
      CELL_SHL: begin
        if (MY_IDX >= cmd.idx) data_nxt = right_q;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
